>>> hw/rtl/ryc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter package
// Shared widths, register codes, component codes, payload structs and the
// BT.601 studio-range weighting and clamping functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ryc_pkg;

   localparam int PIXEL_BITS     = 32;
   localparam int SAMPLE_BITS    = 8;
   localparam int ADDR_BITS      = 25;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_PLANAR_MODE     = 3'd2,
      CSR_BYTES_PER_PIXEL = 3'd3,
      CSR_RED_OFFSET      = 3'd4,
      CSR_GREEN_OFFSET    = 3'd5,
      CSR_BLUE_OFFSET     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      COMP_Y = 2'd0,
      COMP_U = 2'd1,
      COMP_V = 2'd2
   } component_type;

   localparam logic [12:0] RESET_WIDTH        = 13'd640;
   localparam logic [12:0] RESET_HEIGHT       = 13'd480;
   localparam logic        RESET_PLANAR       = 1'b0;
   localparam logic [1:0]  RESET_RED_OFFSET   = 2'd0;
   localparam logic [1:0]  RESET_GREEN_OFFSET = 2'd1;
   localparam logic [1:0]  RESET_BLUE_OFFSET  = 2'd2;

   localparam logic signed [17:0] Y_KR = 18'sd66;
   localparam logic signed [17:0] Y_KG = 18'sd129;
   localparam logic signed [17:0] Y_KB = 18'sd25;
   localparam logic signed [17:0] U_KR = -18'sd38;
   localparam logic signed [17:0] U_KG = -18'sd74;
   localparam logic signed [17:0] U_KB = 18'sd112;
   localparam logic signed [17:0] V_KR = 18'sd112;
   localparam logic signed [17:0] V_KG = -18'sd94;
   localparam logic signed [17:0] V_KB = -18'sd18;

   localparam logic signed [17:0] ROUND_TERM  = 18'sd128;
   localparam logic signed [10:0] LUMA_BIAS   = 11'sd16;
   localparam logic signed [10:0] CHROMA_BIAS = 11'sd128;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] red;
      logic [SAMPLE_BITS-1:0] green;
      logic [SAMPLE_BITS-1:0] blue;
      logic                   chroma;
      logic                   frame_end;
      logic [ADDR_BITS-1:0]   luma_address;
      logic [ADDR_BITS-1:0]   chroma_index;
   } pixel_ctx_type;

   typedef struct packed {
      logic                 planar;
      logic [ADDR_BITS-1:0] first_base;
      logic [ADDR_BITS-1:0] second_base;
   } plane_map_type;

   function automatic logic signed [17:0] weigh(
      input logic [SAMPLE_BITS-1:0] r,
      input logic [SAMPLE_BITS-1:0] g,
      input logic [SAMPLE_BITS-1:0] b,
      input logic signed [17:0]     kr,
      input logic signed [17:0]     kg,
      input logic signed [17:0]     kb
   );
      logic signed [17:0] rs;
      logic signed [17:0] gs;
      logic signed [17:0] bs;
      rs = $signed({10'b0, r});
      gs = $signed({10'b0, g});
      bs = $signed({10'b0, b});
      return (kr * rs) + (kg * gs) + (kb * bs);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] scale_clamp(
      input logic signed [17:0] sum,
      input logic signed [10:0] bias
   );
      logic signed [17:0] rounded;
      logic signed [17:0] shifted;
      logic signed [10:0] level;
      rounded = sum + ROUND_TERM;
      shifted = rounded >>> 8;
      level   = shifted[10:0] + bias;
      if (level < 11'sd0) begin
         return 8'd0;
      end else if (level > 11'sd255) begin
         return 8'd255;
      end else begin
         return level[7:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ryc_req_if.sv
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel carrying one packed source pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ryc_req_if;
   logic                           valid;
   logic                           ready;
   logic [ryc_pkg::PIXEL_BITS-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ryc_rsp_if.sv
// ----------------------------------------------------------------------------
// Sample response channel
// Valid/ready channel carrying one Y, U or V sample with its address per
// transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ryc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ryc_pkg::SAMPLE_BITS-1:0] out_byte;
   logic [ryc_pkg::ADDR_BITS-1:0]   out_address;
   logic [1:0]                      component;
   logic                            last_of_pixel;
   logic                            frame_done;

   modport source (output valid, output out_byte, output out_address, output component,
                   output last_of_pixel, output frame_done, input ready);
   modport sink   (input valid, input out_byte, input out_address, input component,
                   input last_of_pixel, input frame_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ryc_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ryc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ryc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [ryc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ryc_frame_tracker.sv
// ----------------------------------------------------------------------------
// Frame tracker and input register
// Holds the configuration registers, the raster and address counters and the
// plane base addresses; captures each accepted pixel with its context.
// ----------------------------------------------------------------------------
`default_nettype none

module ryc_frame_tracker #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   ryc_req_if.sink                req_chan,
   ryc_csr_if.sink                csr_chan,
   input  logic                   a_take,
   output logic                   a_valid,
   output ryc_pkg::pixel_ctx_type a_ctx,
   output ryc_pkg::plane_map_type plane_map
);

   localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int F_BITS   = W_BITS + H_BITS;
   localparam int A_BITS   = ryc_pkg::ADDR_BITS;

   logic [12:0]         width_ff, width_in;
   logic [12:0]         height_ff, height_in;
   logic                planar_ff, planar_in;
   logic [1:0]          red_off_ff, red_off_in;
   logic [1:0]          green_off_ff, green_off_in;
   logic [1:0]          blue_off_ff, blue_off_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [A_BITS-1:0]   luma_ff, luma_in;
   logic [A_BITS-1:0]   chroma_idx_ff, chroma_idx_in;
   logic                a_valid_ff, a_valid_in;

   ryc_pkg::pixel_ctx_type a_ctx_ff, a_ctx_in;
   ryc_pkg::plane_map_type plane_map_ff, plane_map_in;

   logic              csr_write;
   logic              cfg_hit;
   logic              req_accept;
   logic [W_BITS-1:0] eff_w;
   logic [H_BITS-1:0] eff_h;
   logic [F_BITS-1:0] frame;
   logic [31:0]       frame_wide;
   logic [31:0]       second_wide;
   logic              last_col;
   logic              last_row;
   logic              frame_end;
   logic              chroma;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !a_valid_ff || a_take;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      planar_in    = planar_ff;
      red_off_in   = red_off_ff;
      green_off_in = green_off_ff;
      blue_off_in  = blue_off_ff;
      cfg_hit      = 1'b0;
      if (csr_write) begin
         case (ryc_pkg::csr_index_type'(csr_chan.index))
            ryc_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_chan.data;
               cfg_hit  = 1'b1;
            end
            ryc_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_chan.data;
               cfg_hit   = 1'b1;
            end
            ryc_pkg::CSR_PLANAR_MODE: begin
               planar_in = csr_chan.data[0];
               cfg_hit   = 1'b1;
            end
            ryc_pkg::CSR_BYTES_PER_PIXEL: begin
               cfg_hit = 1'b1;
            end
            ryc_pkg::CSR_RED_OFFSET: begin
               red_off_in = csr_chan.data[1:0];
               cfg_hit    = 1'b1;
            end
            ryc_pkg::CSR_GREEN_OFFSET: begin
               green_off_in = csr_chan.data[1:0];
               cfg_hit      = 1'b1;
            end
            ryc_pkg::CSR_BLUE_OFFSET: begin
               blue_off_in = csr_chan.data[1:0];
               cfg_hit     = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff < 13'd2) begin
         eff_w = W_BITS'(2);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = W_BITS'(MAX_WIDTH);
      end else begin
         eff_w = W_BITS'(width_ff);
      end
      if (height_ff < 13'd2) begin
         eff_h = H_BITS'(2);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = H_BITS'(MAX_HEIGHT);
      end else begin
         eff_h = H_BITS'(height_ff);
      end
      frame       = F_BITS'(eff_w) * F_BITS'(eff_h);
      frame_wide  = 32'(frame);
      second_wide = frame_wide + (frame_wide >> 2);
      plane_map_in.planar      = planar_ff;
      plane_map_in.first_base  = frame_wide[A_BITS-1:0];
      plane_map_in.second_base = second_wide[A_BITS-1:0];
   end

   always_comb begin
      last_col  = W_BITS'(col_ff) >= (eff_w - W_BITS'(1));
      last_row  = H_BITS'(row_ff) >= (eff_h - H_BITS'(1));
      frame_end = last_col && last_row;
      chroma    = !col_ff[0] && !row_ff[0];

      col_in        = col_ff;
      row_in        = row_ff;
      luma_in       = luma_ff;
      chroma_idx_in = chroma_idx_ff;
      if (cfg_hit) begin
         col_in        = '0;
         row_in        = '0;
         luma_in       = '0;
         chroma_idx_in = '0;
      end else if (req_accept) begin
         luma_in       = luma_ff + A_BITS'(1);
         chroma_idx_in = chroma_idx_ff + A_BITS'(chroma);
         if (frame_end) begin
            col_in        = '0;
            row_in        = '0;
            luma_in       = '0;
            chroma_idx_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end

      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (a_take) begin
         a_valid_in = 1'b0;
      end

      a_ctx_in = a_ctx_ff;
      if (req_accept) begin
         a_ctx_in.red          = req_chan.pixel_word[{red_off_ff, 3'b000} +: 8];
         a_ctx_in.green        = req_chan.pixel_word[{green_off_ff, 3'b000} +: 8];
         a_ctx_in.blue         = req_chan.pixel_word[{blue_off_ff, 3'b000} +: 8];
         a_ctx_in.chroma       = chroma;
         a_ctx_in.frame_end    = frame_end;
         a_ctx_in.luma_address = luma_ff;
         a_ctx_in.chroma_index = chroma_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= ryc_pkg::RESET_WIDTH;
         height_ff     <= ryc_pkg::RESET_HEIGHT;
         planar_ff     <= ryc_pkg::RESET_PLANAR;
         red_off_ff    <= ryc_pkg::RESET_RED_OFFSET;
         green_off_ff  <= ryc_pkg::RESET_GREEN_OFFSET;
         blue_off_ff   <= ryc_pkg::RESET_BLUE_OFFSET;
         col_ff        <= '0;
         row_ff        <= '0;
         luma_ff       <= '0;
         chroma_idx_ff <= '0;
         a_valid_ff    <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         planar_ff     <= planar_in;
         red_off_ff    <= red_off_in;
         green_off_ff  <= green_off_in;
         blue_off_ff   <= blue_off_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         luma_ff       <= luma_in;
         chroma_idx_ff <= chroma_idx_in;
         a_valid_ff    <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ctx_ff     <= a_ctx_in;
      plane_map_ff <= plane_map_in;
   end

   assign a_valid   = a_valid_ff;
   assign a_ctx     = a_ctx_ff;
   assign plane_map = plane_map_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ryc_sample_emitter.sv
// ----------------------------------------------------------------------------
// Sample emitter
// Converts the held pixel to Y, U and V with their addresses into the result
// register, then steps through its Y and, for chroma pixels, U and V transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module ryc_sample_emitter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   a_valid,
   input  ryc_pkg::pixel_ctx_type a_ctx,
   input  ryc_pkg::plane_map_type plane_map,
   output logic                   a_take,
   ryc_rsp_if.source              rsp_chan
);

   localparam int A_BITS = ryc_pkg::ADDR_BITS;

   typedef struct packed {
      logic [7:0]        y_val;
      logic [7:0]        u_val;
      logic [7:0]        v_val;
      logic [A_BITS-1:0] luma_address;
      logic [A_BITS-1:0] u_address;
      logic [A_BITS-1:0] v_address;
      logic              chroma;
      logic              frame_end;
   } sample_set_type;

   sample_set_type         set_ff, set_in, fresh;
   ryc_pkg::component_type phase_ff, phase_in;
   logic                   b_valid_ff, b_valid_in;

   logic              rsp_fire;
   logic              at_last;
   logic [A_BITS-1:0] twice_idx;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign at_last  = (phase_ff == ryc_pkg::COMP_V) ||
                     ((phase_ff == ryc_pkg::COMP_Y) && !set_ff.chroma);
   assign a_take   = a_valid && (!b_valid_ff || (rsp_fire && at_last));

   always_comb begin
      twice_idx = {a_ctx.chroma_index[A_BITS-2:0], 1'b0};
      fresh.y_val = ryc_pkg::scale_clamp(
         ryc_pkg::weigh(a_ctx.red, a_ctx.green, a_ctx.blue,
                        ryc_pkg::Y_KR, ryc_pkg::Y_KG, ryc_pkg::Y_KB),
         ryc_pkg::LUMA_BIAS);
      fresh.u_val = ryc_pkg::scale_clamp(
         ryc_pkg::weigh(a_ctx.red, a_ctx.green, a_ctx.blue,
                        ryc_pkg::U_KR, ryc_pkg::U_KG, ryc_pkg::U_KB),
         ryc_pkg::CHROMA_BIAS);
      fresh.v_val = ryc_pkg::scale_clamp(
         ryc_pkg::weigh(a_ctx.red, a_ctx.green, a_ctx.blue,
                        ryc_pkg::V_KR, ryc_pkg::V_KG, ryc_pkg::V_KB),
         ryc_pkg::CHROMA_BIAS);
      fresh.luma_address = a_ctx.luma_address;
      if (plane_map.planar) begin
         fresh.u_address = plane_map.first_base + a_ctx.chroma_index;
         fresh.v_address = plane_map.second_base + a_ctx.chroma_index;
      end else begin
         fresh.u_address = plane_map.first_base + twice_idx;
         fresh.v_address = plane_map.first_base + twice_idx + A_BITS'(1);
      end
      fresh.chroma    = a_ctx.chroma;
      fresh.frame_end = a_ctx.frame_end;

      set_in = a_take ? fresh : set_ff;
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      phase_in   = phase_ff;
      if (rsp_fire) begin
         if (at_last) begin
            phase_in   = ryc_pkg::COMP_Y;
            b_valid_in = 1'b0;
         end else if (phase_ff == ryc_pkg::COMP_Y) begin
            phase_in = ryc_pkg::COMP_U;
         end else begin
            phase_in = ryc_pkg::COMP_V;
         end
      end
      if (a_take) begin
         b_valid_in = 1'b1;
         phase_in   = ryc_pkg::COMP_Y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         phase_ff   <= ryc_pkg::COMP_Y;
      end else begin
         b_valid_ff <= b_valid_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff <= set_in;
   end

   assign rsp_chan.valid     = b_valid_ff;
   assign rsp_chan.component = phase_ff;

   always_comb begin
      case (phase_ff)
         ryc_pkg::COMP_Y: begin
            rsp_chan.out_byte      = set_ff.y_val;
            rsp_chan.out_address   = set_ff.luma_address;
            rsp_chan.last_of_pixel = !set_ff.chroma;
            rsp_chan.frame_done    = !set_ff.chroma && set_ff.frame_end;
         end
         ryc_pkg::COMP_U: begin
            rsp_chan.out_byte      = set_ff.u_val;
            rsp_chan.out_address   = set_ff.u_address;
            rsp_chan.last_of_pixel = 1'b0;
            rsp_chan.frame_done    = 1'b0;
         end
         ryc_pkg::COMP_V: begin
            rsp_chan.out_byte      = set_ff.v_val;
            rsp_chan.out_address   = set_ff.v_address;
            rsp_chan.last_of_pixel = 1'b1;
            rsp_chan.frame_done    = set_ff.frame_end;
         end
         default: begin
            rsp_chan.out_byte      = '0;
            rsp_chan.out_address   = '0;
            rsp_chan.last_of_pixel = 1'b0;
            rsp_chan.frame_done    = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/rgb_to_yuv420_converter_unit.sv
// A pixel's samples are shown once it has passed the input and result registers.
// Throughput: 1 pixel per cycle on pixels that give only Y, when the receiver is
//   ready; a chroma pixel holds the result register for 3 transfers.
// Reset: configuration returns to defaults, counters to frame start, stages empty;
//   any write to a defined configuration register restarts the frame.
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter
// Input register with raster tracking, then BT.601 conversion into a result
// register that issues Y and, on even rows and columns, U and V.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_yuv420_converter_unit #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic      clock,
   input  logic      reset,
   ryc_req_if.sink   req_chan,
   ryc_rsp_if.source rsp_chan,
   ryc_csr_if.sink   csr_chan
);

   logic                   a_valid;
   logic                   a_take;
   ryc_pkg::pixel_ctx_type a_ctx;
   ryc_pkg::plane_map_type plane_map;

   ryc_frame_tracker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .a_take    (a_take),
      .a_valid   (a_valid),
      .a_ctx     (a_ctx),
      .plane_map (plane_map)
   );

   ryc_sample_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .a_valid   (a_valid),
      .a_ctx     (a_ctx),
      .plane_map (plane_map),
      .a_take    (a_take),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   hold_input_stage: assert property (@(posedge clock) disable iff (reset)
      a_valid && !a_take |=> a_valid && $stable(a_ctx))
      else $error("input stage lost or changed a held pixel");

   v_follows_u: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.component == ryc_pkg::COMP_U
      |=> rsp_chan.valid && rsp_chan.component == ryc_pkg::COMP_V)
      else $error("U transfer not followed by V");

   drain_when_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_of_pixel && !a_valid
      |=> !rsp_chan.valid)
      else $error("result shown with no pixel behind it");
`endif

endmodule

`default_nettype wire

>>> tb/sv/rgb_to_yuv420_converter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter testbench
// Streams packed pixels through the converter under a range of frame sizes,
// plane layouts and byte orders, predicts every Y, U and V sample with its
// address and frame markers, and compares each response transfer in order.
// Both channels idle and stall at random; register writes happen only when
// the converter has drained.
// ----------------------------------------------------------------------------

module rgb_to_yuv420_converter_unit_tb;

   localparam int IMAGE_MAX_WIDTH  = 4096;
   localparam int IMAGE_MAX_HEIGHT = 4096;
   localparam logic [2:0] RESET_BYTES_PER_PIXEL = 3'd4;
   localparam logic [ryc_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 10;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic [ryc_pkg::SAMPLE_BITS-1:0] value;
      logic [ryc_pkg::ADDR_BITS-1:0]   address;
      ryc_pkg::component_type          comp;
      logic                            last_of_pixel;
      logic                            frame_done;
   } yuv_sample_type;

   logic clock;
   logic reset;

   ryc_req_if req_chan ();
   ryc_rsp_if rsp_chan ();
   ryc_csr_if csr_chan ();

   rgb_to_yuv420_converter_unit #(
      .MAX_WIDTH  (IMAGE_MAX_WIDTH),
      .MAX_HEIGHT (IMAGE_MAX_HEIGHT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [ryc_pkg::PIXEL_BITS-1:0] pending_pixels[$];
   yuv_sample_type                 expected_samples[$];
   yuv_sample_type                 want;
   int unsigned                    error_count = 0;
   int unsigned                    cycle_count = 0;

   // converter settings and raster position as predicted
   logic [12:0]                   cfg_width;
   logic [12:0]                   cfg_height;
   logic                          cfg_planar;
   logic [2:0]                    cfg_bytes_per_pixel;
   logic [1:0]                    cfg_red_pos;
   logic [1:0]                    cfg_green_pos;
   logic [1:0]                    cfg_blue_pos;
   int unsigned                   row_pos;
   int unsigned                   col_pos;
   logic [ryc_pkg::ADDR_BITS-1:0] luma_addr;
   logic [ryc_pkg::ADDR_BITS-1:0] chroma_addr_a;
   logic [ryc_pkg::ADDR_BITS-1:0] chroma_addr_b;

   int          burst_left = 0;
   int          gap_left = 0;
   int unsigned stall_step = 0;
   logic [31:0] stall_mask = '1;
   int          hold_off_left = 0;
   int          hold_off_seen = 0;
   int          hold_off_request = 0;

   function automatic int unsigned active_width();
      if (cfg_width < 13'd2) return 2;
      if (cfg_width > IMAGE_MAX_WIDTH) return IMAGE_MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned active_height();
      if (cfg_height < 13'd2) return 2;
      if (cfg_height > IMAGE_MAX_HEIGHT) return IMAGE_MAX_HEIGHT;
      return cfg_height;
   endfunction

   function automatic void restart_frame();
      int unsigned frame;
      frame = active_width() * active_height();
      row_pos = 0;
      col_pos = 0;
      luma_addr = '0;
      chroma_addr_a = frame[ryc_pkg::ADDR_BITS-1:0];
      chroma_addr_b = ryc_pkg::ADDR_BITS'(frame + frame / 4);
   endfunction

   function automatic void apply_register(
      input logic [ryc_pkg::CSR_INDEX_BITS-1:0] index,
      input logic [ryc_pkg::CSR_DATA_BITS-1:0]  value);
      case (index)
         ryc_pkg::CSR_IMAGE_WIDTH:     cfg_width = value;
         ryc_pkg::CSR_IMAGE_HEIGHT:    cfg_height = value;
         ryc_pkg::CSR_PLANAR_MODE:     cfg_planar = value[0];
         ryc_pkg::CSR_BYTES_PER_PIXEL: cfg_bytes_per_pixel = value[2:0];
         ryc_pkg::CSR_RED_OFFSET:      cfg_red_pos = value[1:0];
         ryc_pkg::CSR_GREEN_OFFSET:    cfg_green_pos = value[1:0];
         ryc_pkg::CSR_BLUE_OFFSET:     cfg_blue_pos = value[1:0];
         default:                      return;
      endcase
      restart_frame();
   endfunction

   // floor((sum + 128) / 256) + bias, clamped to a byte
   function automatic logic [7:0] clamp_level(input int sum, input int bias);
      int level;
      level = ((sum + 128) >>> 8) + bias;
      if (level < 0) return 8'd0;
      if (level > 255) return 8'd255;
      return level[7:0];
   endfunction

   function automatic void push_sample(input logic [7:0] value,
                                       input logic [ryc_pkg::ADDR_BITS-1:0] address,
                                       input ryc_pkg::component_type comp,
                                       input logic last, input logic done);
      yuv_sample_type s;
      s.value = value;
      s.address = address;
      s.comp = comp;
      s.last_of_pixel = last;
      s.frame_done = done;
      expected_samples.push_back(s);
   endfunction

   function automatic void convert_pixel(input logic [ryc_pkg::PIXEL_BITS-1:0] word);
      int          r;
      int          g;
      int          b;
      int unsigned w;
      int unsigned h;
      logic        on_chroma;
      logic        at_end;
      r = int'(word[8*cfg_red_pos +: 8]);
      g = int'(word[8*cfg_green_pos +: 8]);
      b = int'(word[8*cfg_blue_pos +: 8]);
      w = active_width();
      h = active_height();
      on_chroma = !row_pos[0] && !col_pos[0];
      at_end = (row_pos >= h - 1) && (col_pos >= w - 1);
      push_sample(clamp_level(66 * r + 129 * g + 25 * b, 16), luma_addr, ryc_pkg::COMP_Y,
                  !on_chroma, !on_chroma && at_end);
      luma_addr = luma_addr + 1'b1;
      if (on_chroma) begin
         push_sample(clamp_level(-38 * r - 74 * g + 112 * b, 128), chroma_addr_a,
                     ryc_pkg::COMP_U, 1'b0, 1'b0);
         chroma_addr_a = chroma_addr_a + 1'b1;
         if (cfg_planar) begin
            push_sample(clamp_level(112 * r - 94 * g - 18 * b, 128), chroma_addr_b,
                        ryc_pkg::COMP_V, 1'b1, at_end);
            chroma_addr_b = chroma_addr_b + 1'b1;
         end else begin
            push_sample(clamp_level(112 * r - 94 * g - 18 * b, 128), chroma_addr_a,
                        ryc_pkg::COMP_V, 1'b1, at_end);
            chroma_addr_a = chroma_addr_a + 1'b1;
         end
      end
      if (at_end) begin
         restart_frame();
      end else if (col_pos >= w - 1) begin
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
   endfunction

   function automatic logic [ryc_pkg::PIXEL_BITS-1:0] random_pixel();
      logic [ryc_pkg::PIXEL_BITS-1:0] word;
      word = $urandom;
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(0, 7) == 0) begin
            word[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
      end
      return word;
   endfunction

   task automatic wait_for_drain();
      while (pending_pixels.size() != 0 || req_chan.valid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [ryc_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [ryc_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= value;
      do begin
         @(posedge clock);
      end while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      apply_register(index, value);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // pixel driver: bursts of offers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            convert_pixel(req_chan.pixel_word);
            void'(pending_pixels.pop_front());
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_chan.valid <= 1'b1;
               req_chan.pixel_word <= pending_pixels[0];
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // sample monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected sample: out_byte %0d out_address %0d component %0d",
                      rsp_chan.out_byte, rsp_chan.out_address, rsp_chan.component);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_chan.out_byte !== want.value) begin
                  $error("out_byte: expected %0d, actual %0d", want.value, rsp_chan.out_byte);
                  error_count++;
               end
               if (rsp_chan.out_address !== want.address) begin
                  $error("out_address: expected %0d, actual %0d", want.address,
                         rsp_chan.out_address);
                  error_count++;
               end
               if (rsp_chan.component !== want.comp) begin
                  $error("component: expected %0d, actual %0d", want.comp, rsp_chan.component);
                  error_count++;
               end
               if (rsp_chan.last_of_pixel !== want.last_of_pixel) begin
                  $error("last_of_pixel: expected %0d, actual %0d", want.last_of_pixel,
                         rsp_chan.last_of_pixel);
                  error_count++;
               end
               if (rsp_chan.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0d, actual %0d", want.frame_done,
                         rsp_chan.frame_done);
                  error_count++;
               end
            end
         end
         stall_step++;
         if (stall_step % 32 == 0) begin
            stall_mask = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
         end
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_off_seen != hold_off_request) begin
            hold_off_seen = hold_off_request;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= stall_mask[stall_step % 32];
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          item_total;
      int          split;
      logic [12:0] width_val;
      logic [12:0] height_val;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.pixel_word = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;

      cfg_width = ryc_pkg::RESET_WIDTH;
      cfg_height = ryc_pkg::RESET_HEIGHT;
      cfg_planar = ryc_pkg::RESET_PLANAR;
      cfg_bytes_per_pixel = RESET_BYTES_PER_PIXEL;
      cfg_red_pos = ryc_pkg::RESET_RED_OFFSET;
      cfg_green_pos = ryc_pkg::RESET_GREEN_OFFSET;
      cfg_blue_pos = ryc_pkg::RESET_BLUE_OFFSET;
      restart_frame();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full-range words
      pending_pixels.push_back(32'h0000_0000);
      pending_pixels.push_back(32'hFFFF_FFFF);
      wait_for_drain();

      // smallest frame, three-byte pixels, red and green both on the top byte
      write_register(ryc_pkg::CSR_IMAGE_WIDTH, 13'd2);
      write_register(ryc_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      write_register(ryc_pkg::CSR_PLANAR_MODE, 13'd0);
      write_register(ryc_pkg::CSR_BYTES_PER_PIXEL, 13'd3);
      write_register(ryc_pkg::CSR_RED_OFFSET, 13'd3);
      write_register(ryc_pkg::CSR_GREEN_OFFSET, 13'd3);
      write_register(ryc_pkg::CSR_BLUE_OFFSET, 13'd0);
      pending_pixels.push_back(32'hFF00_0000);
      pending_pixels.push_back(32'h0000_00FF);
      wait_for_drain();
      // unused register index: frame must continue
      write_register(CSR_UNUSED_INDEX, 13'h1FFF);
      pending_pixels.push_back(32'h1234_5678);
      pending_pixels.push_back(32'h8080_8080);
      pending_pixels.push_back(32'h7F7F_7F7F);
      wait_for_drain();

      // out-of-range sizes saturate
      write_register(ryc_pkg::CSR_IMAGE_WIDTH, 13'h1FFF);
      write_register(ryc_pkg::CSR_IMAGE_HEIGHT, 13'd0);
      write_register(ryc_pkg::CSR_PLANAR_MODE, 13'd1);
      pending_pixels.push_back(32'hA5A5_5A5A);
      pending_pixels.push_back(32'h5A5A_A5A5);
      wait_for_drain();

      // largest frame, planar
      write_register(ryc_pkg::CSR_IMAGE_WIDTH, 13'd4096);
      write_register(ryc_pkg::CSR_IMAGE_HEIGHT, 13'd4096);
      pending_pixels.push_back(32'h00FF_00FF);
      pending_pixels.push_back(32'hFF00_FF00);
      wait_for_drain();

      // odd frame size, planar, wrap into the next frame
      write_register(ryc_pkg::CSR_IMAGE_WIDTH, 13'd3);
      write_register(ryc_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      write_register(ryc_pkg::CSR_BYTES_PER_PIXEL, 13'd4);
      write_register(ryc_pkg::CSR_RED_OFFSET, 13'd2);
      write_register(ryc_pkg::CSR_GREEN_OFFSET, 13'd1);
      write_register(ryc_pkg::CSR_BLUE_OFFSET, 13'd0);
      repeat (10) pending_pixels.push_back(random_pixel());
      wait_for_drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0:       width_val = 13'd0;
            1:       width_val = 13'h1FFF;
            2:       width_val = 13'd4096;
            default: width_val = 13'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 9))
            0:       height_val = 13'd1;
            1:       height_val = 13'd4097;
            default: height_val = 13'($urandom_range(2, 6));
         endcase
         write_register(ryc_pkg::CSR_IMAGE_WIDTH, width_val);
         write_register(ryc_pkg::CSR_IMAGE_HEIGHT, height_val);
         write_register(ryc_pkg::CSR_PLANAR_MODE, 13'($urandom));
         write_register(ryc_pkg::CSR_BYTES_PER_PIXEL, 13'($urandom));
         write_register(ryc_pkg::CSR_RED_OFFSET, 13'($urandom));
         write_register(ryc_pkg::CSR_GREEN_OFFSET, 13'($urandom));
         write_register(ryc_pkg::CSR_BLUE_OFFSET, 13'($urandom));

         item_total = $urandom_range(25, 45);
         split = (phase % 2 == 1) ? $urandom_range(5, item_total - 5) : item_total;
         repeat (split) pending_pixels.push_back(random_pixel());
         if (phase == 2) begin
            // hold the receiver off while pixels keep coming
            @(posedge clock);
            hold_off_request <= hold_off_request + 1;
         end
         if (split != item_total) begin
            // pause the sender mid-frame until every sample is back
            wait_for_drain();
            if ($urandom_range(0, 1) == 1) begin
               write_register(CSR_UNUSED_INDEX, 13'($urandom));
            end
            repeat (item_total - split) pending_pixels.push_back(random_pixel());
         end
         wait_for_drain();
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ryc_pkg.sv
hw/rtl/ryc_req_if.sv
hw/rtl/ryc_rsp_if.sv
hw/rtl/ryc_csr_if.sv
hw/rtl/ryc_frame_tracker.sv
hw/rtl/ryc_sample_emitter.sv
hw/rtl/rgb_to_yuv420_converter_unit.sv
tb/sv/rgb_to_yuv420_converter_unit_tb.sv
